/* src/rbd_pkg.sv */
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUT_BACK   = 3'd0,
    CMD_PUT_FRONT  = 3'd1,
    CMD_TAKE_BACK  = 3'd2,
    CMD_TAKE_FRONT = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_READ_INDEX = 3'd6,
    CMD_FIND       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_FIND
  } state_t;

  typedef struct packed {
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
  } ram_req_t;

endpackage

/* src/rbd_ram.sv */
`timescale 1ns / 1ps

module rbd_ram (
  input  logic                              clk,
  input  rbd_pkg::ram_req_t                 req,
  output logic [rbd_pkg::WORD_WIDTH-1:0]    rd_data
);

  logic [rbd_pkg::WORD_WIDTH-1:0] mem [rbd_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* src/ring_buffer_deque.sv */
`timescale 1ns / 1ps

// Double-ended queue of DEPTH words held in a ring in one synchronous RAM.
// Input channel in_*: one request per accepted beat; in_tuser carries the
// command, in_tdata the word or key and the logical index. Output channel
// out_*: exactly one result per request, in request order; out_tuser holds
// the status, out_tdata the word read, the find position and the count.
// How each request is served before its result enters the output register:
//   push, pop, or peek, read index or find on an empty queue: at accept
//   peek front or back: one RAM read
//   read index: index reduced modulo count (one subtract per cycle), one read
//   find: entries read from the front and compared in turn until a match or the last
// The single RAM read port, one entry per cycle, sets the find time.
// One request is in work at a time; the next is taken once the block is
// idle and the output register is empty or being emptied.
// If the receiver stalls, the result holds in the output register and no
// further request is accepted until it is taken.
// Reset clears pointers, count and control; RAM contents are not cleared,
// and only held entries are ever read.
module ring_buffer_deque (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_in[31:0], index[35:32], zero[39:36]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // data_out[31:0], position[35:32], count[40:36], zero
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int PW = rbd_pkg::PTR_W;
  localparam int CW = rbd_pkg::CNT_W;
  localparam int WW = rbd_pkg::WORD_WIDTH;
  localparam logic [CW-1:0] FULL_CNT = CW'(rbd_pkg::DEPTH);

  rbd_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [WW-1:0] key_r, key_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [PW-1:0] kc_r, kc_nxt;
  logic          cmpv_r, cmpv_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [WW-1:0] out_data_r, out_data_nxt;
  logic [PW-1:0] out_pos_r, out_pos_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic [CW-1:0] out_cnt_r, out_cnt_nxt;

  rbd_pkg::ram_req_t ram_req;
  logic [WW-1:0]     rd_data;

  logic          accept, out_free, load;
  logic [WW-1:0] ld_data;
  logic [PW-1:0] ld_pos;
  logic [1:0]    ld_stat;
  logic [CW-1:0] ld_cnt;

  rbd_pkg::cmd_t in_cmd;
  logic [WW-1:0] in_word;
  logic [PW-1:0] in_index;

  assign in_cmd   = rbd_pkg::cmd_t'(in_tuser);
  assign in_word  = in_tdata[WW-1:0];
  assign in_index = in_tdata[WW+PW-1:WW];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == rbd_pkg::S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  rbd_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    kc_nxt    = kc_r;
    cmpv_nxt  = cmpv_r;
    ram_req   = '0;
    load      = 1'b0;
    ld_data   = '0;
    ld_pos    = '0;
    ld_stat   = rbd_pkg::ST_OK;
    ld_cnt    = cnt_r;

    case (state_r)
      rbd_pkg::S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            rbd_pkg::CMD_PUT_BACK, rbd_pkg::CMD_PUT_FRONT: begin
              load = 1'b1;
              if (cnt_r == FULL_CNT) begin
                ld_stat = rbd_pkg::ST_FULL;
              end else begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_data = in_word;
                cnt_nxt         = cnt_r + 1'b1;
                ld_cnt          = cnt_r + 1'b1;
                if (in_cmd == rbd_pkg::CMD_PUT_BACK) begin
                  ram_req.wr_addr = tail_r;
                  tail_nxt        = tail_r + 1'b1;
                end else begin
                  ram_req.wr_addr = head_r - 1'b1;
                  head_nxt        = head_r - 1'b1;
                end
              end
            end
            rbd_pkg::CMD_TAKE_BACK, rbd_pkg::CMD_TAKE_FRONT: begin
              load = 1'b1;
              if (cnt_r == '0) begin
                ld_stat = rbd_pkg::ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
                ld_cnt  = cnt_r - 1'b1;
                if (in_cmd == rbd_pkg::CMD_TAKE_BACK) begin
                  tail_nxt = tail_r - 1'b1;
                end else begin
                  head_nxt = head_r + 1'b1;
                end
              end
            end
            rbd_pkg::CMD_PEEK_FRONT, rbd_pkg::CMD_PEEK_BACK: begin
              if (cnt_r == '0) begin
                load    = 1'b1;
                ld_stat = rbd_pkg::ST_EMPTY;
              end else begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = (in_cmd == rbd_pkg::CMD_PEEK_FRONT) ? head_r
                                                                      : tail_r - 1'b1;
                state_nxt       = rbd_pkg::S_READ;
              end
            end
            rbd_pkg::CMD_READ_INDEX: begin
              if (cnt_r == '0) begin
                load    = 1'b1;
                ld_stat = rbd_pkg::ST_EMPTY;
              end else begin
                rem_nxt   = in_index;
                state_nxt = rbd_pkg::S_MOD;
              end
            end
            rbd_pkg::CMD_FIND: begin
              key_nxt = in_word;
              if (cnt_r == '0) begin
                load    = 1'b1;
                ld_stat = rbd_pkg::ST_NOT_FOUND;
              end else begin
                k_nxt     = '0;
                cmpv_nxt  = 1'b0;
                state_nxt = rbd_pkg::S_FIND;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end

      rbd_pkg::S_MOD: begin
        // reduce the index by repeated subtraction of the count
        if ({1'b0, rem_r} < cnt_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = head_r + rem_r;
          state_nxt       = rbd_pkg::S_READ;
        end else begin
          rem_nxt = rem_r - cnt_r[PW-1:0];
        end
      end

      rbd_pkg::S_READ: begin
        load      = 1'b1;
        ld_data   = rd_data;
        state_nxt = rbd_pkg::S_IDLE;
      end

      rbd_pkg::S_FIND: begin
        // issue one read per cycle, compare the word read the cycle before
        if (cmpv_r && rd_data == key_r) begin
          load      = 1'b1;
          ld_pos    = kc_r;
          state_nxt = rbd_pkg::S_IDLE;
        end else if (cmpv_r && {1'b0, kc_r} == cnt_r - 1'b1) begin
          load      = 1'b1;
          ld_stat   = rbd_pkg::ST_NOT_FOUND;
          state_nxt = rbd_pkg::S_IDLE;
        end else begin
          cmpv_nxt = k_r < cnt_r;
          if (k_r < cnt_r) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = head_r + k_r[PW-1:0];
            kc_nxt          = k_r[PW-1:0];
            k_nxt           = k_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = rbd_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_data_nxt  = load ? ld_data : out_data_r;
    out_pos_nxt   = load ? ld_pos  : out_pos_r;
    out_stat_nxt  = load ? ld_stat : out_stat_r;
    out_cnt_nxt   = load ? ld_cnt  : out_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbd_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      cmpv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      cmpv_r      <= cmpv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    rem_r      <= rem_nxt;
    kc_r       <= kc_nxt;
    out_data_r <= out_data_nxt;
    out_pos_r  <= out_pos_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_pos_r, out_data_r};
  assign out_tuser  = out_stat_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("fill count exceeds depth");

  a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(tail_r - head_r) == cnt_r[PW-1:0])
    else $error("pointers disagree with fill count");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != rbd_pkg::S_IDLE |-> !in_tready)
    else $error("request taken while busy");

  a_count_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r == cnt_r)
    else $error("result count differs from held count");

  a_push_pop_1cyc: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == rbd_pkg::CMD_PUT_BACK || in_cmd == rbd_pkg::CMD_PUT_FRONT ||
               in_cmd == rbd_pkg::CMD_TAKE_BACK || in_cmd == rbd_pkg::CMD_TAKE_FRONT)
    |=> out_valid_r && state_r == rbd_pkg::S_IDLE)
    else $error("push or pop result not ready after one cycle");

endmodule
